@@ rtl/dual_servo_pulse_generator_defines.svh @@
// ----------------------------------------------------------------------------
// dual_servo_pulse_generator_defines
// assertion macros shared by the servo pulse generator modules
// ----------------------------------------------------------------------------
`ifndef DUAL_SERVO_PULSE_GENERATOR_DEFINES_SVH
`define DUAL_SERVO_PULSE_GENERATOR_DEFINES_SVH

// same-cycle implication, idle during reset
`define DSPG_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, idle during reset
`define DSPG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/dspg_pkg.sv @@
// ----------------------------------------------------------------------------
// dspg_pkg
// types and constants of the dual servo pulse generator
// ----------------------------------------------------------------------------
`default_nettype none

package dspg_pkg;

	localparam int NUM_REGS = 7;

	// request codes
	localparam logic [1:0] REQ_TICK  = 2'd0;
	localparam logic [1:0] REQ_WRITE = 2'd1;
	localparam logic [1:0] REQ_READ  = 2'd2;

	// register indexes
	localparam logic [2:0] REG_CTRL  = 3'd0;
	localparam logic [2:0] REG_POS_A = 3'd1;
	localparam logic [2:0] REG_POS_B = 3'd2;
	localparam logic [2:0] REG_MIN_A = 3'd3;
	localparam logic [2:0] REG_MAX_A = 3'd4;
	localparam logic [2:0] REG_MIN_B = 3'd5;
	localparam logic [2:0] REG_MAX_B = 3'd6;

	// configuration indexes
	localparam logic CFG_PERIOD = 1'b0;
	localparam logic CFG_BASE   = 1'b1;

	localparam logic [7:0] CTRL_MASK  = 8'h87;
	localparam int         SAVE_BIT   = 7;
	localparam int         LASER_BIT  = 2;
	localparam logic [7:0] MIN_FLOOR  = 8'd2;

	localparam logic [11:0] PERIOD_RST = 12'd1264;
	localparam logic [9:0]  BASE_RST   = 10'd64;

	typedef logic [7:0] reg_byte_t;
	typedef reg_byte_t [NUM_REGS-1:0] reg_file_t;

	localparam reg_file_t REGS_RST = {8'd255, 8'd2, 8'd255, 8'd2, 8'd128, 8'd128, 8'd0};

	// timer control from the register file
	typedef struct packed {
		logic       tick;
		logic       wr;
		logic [1:0] en;
		logic [7:0] cmp_a;
		logic [7:0] cmp_b;
	} tmr_ctl_t;

endpackage

`default_nettype wire

@@ rtl/dspg_regfile.sv @@
// ----------------------------------------------------------------------------
// dspg_regfile
// byte register file, compare value scaling, laser and save logic
// ----------------------------------------------------------------------------
`default_nettype none
`include "dual_servo_pulse_generator_defines.svh"

module dspg_regfile (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              fire,
	input  wire logic [1:0]        req,
	input  wire logic [2:0]        addr,
	input  wire logic [7:0]        data,
	output dspg_pkg::tmr_ctl_t     tmr_ctl,
	output logic                   laser_next,
	output logic [7:0]             rd_data,
	output logic                   save
);

	dspg_pkg::reg_file_t regs_q;
	dspg_pkg::reg_file_t regs_new;
	logic [7:0]          cmp_a_q;
	logic [7:0]          cmp_b_q;
	logic                laser_q;
	logic                wr;
	logic [7:0]          ctl_new;
	logic [7:0]          scaled_a;
	logic [7:0]          scaled_b;

	function automatic logic [7:0] scale_pos(input logic [7:0] lo, input logic [7:0] hi,
		input logic [7:0] pos);
		logic signed [8:0]  diff;
		logic signed [17:0] prod;
		logic [9:0]         sum;
		diff = $signed({1'b0, hi}) - $signed({1'b0, lo});
		prod = diff * $signed({1'b0, pos});
		sum  = {2'b00, lo} + prod[17:8];
		return sum[7:0];
	endfunction

	assign wr      = fire && (req == dspg_pkg::REQ_WRITE);
	assign ctl_new = (addr == dspg_pkg::REG_CTRL) ? (data & dspg_pkg::CTRL_MASK) : regs_q[0];

	always_comb begin
		regs_new = regs_q;
		for (int i = 0; i < dspg_pkg::NUM_REGS; i++) begin
			if (addr == 3'(i)) begin
				if (3'(i) == dspg_pkg::REG_CTRL) begin
					regs_new[i] = ctl_new & ~(8'd1 << dspg_pkg::SAVE_BIT);
				end else if (3'(i) >= dspg_pkg::REG_MIN_A && data < dspg_pkg::MIN_FLOOR) begin
					regs_new[i] = dspg_pkg::MIN_FLOOR;
				end else begin
					regs_new[i] = data;
				end
			end
		end
	end

	assign scaled_a = scale_pos(regs_new[dspg_pkg::REG_MIN_A], regs_new[dspg_pkg::REG_MAX_A],
		regs_new[dspg_pkg::REG_POS_A]);
	assign scaled_b = scale_pos(regs_new[dspg_pkg::REG_MIN_B], regs_new[dspg_pkg::REG_MAX_B],
		regs_new[dspg_pkg::REG_POS_B]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q  <= dspg_pkg::REGS_RST;
			cmp_a_q <= '0;
			cmp_b_q <= '0;
			laser_q <= 1'b0;
		end else if (wr) begin
			regs_q  <= regs_new;
			laser_q <= ctl_new[dspg_pkg::LASER_BIT];
			if (ctl_new[0]) begin
				cmp_a_q <= scaled_a;
			end
			if (ctl_new[1]) begin
				cmp_b_q <= scaled_b;
			end
		end
	end

	always_comb begin
		tmr_ctl.tick  = fire && (req == dspg_pkg::REQ_TICK);
		tmr_ctl.wr    = wr;
		tmr_ctl.en    = wr ? ctl_new[1:0] : regs_q[0][1:0];
		tmr_ctl.cmp_a = cmp_a_q;
		tmr_ctl.cmp_b = cmp_b_q;
	end

	assign laser_next = wr ? ctl_new[dspg_pkg::LASER_BIT] : laser_q;
	assign save       = wr && (addr == dspg_pkg::REG_CTRL) && data[dspg_pkg::SAVE_BIT];
	assign rd_data    = (req == dspg_pkg::REQ_READ && addr <= dspg_pkg::REG_MAX_B) ?
		regs_q[addr] : 8'd0;

	`DSPG_ASSERT_NOW(a_save_bit_clear, clk, arst_n, 1'b1, !regs_q[0][dspg_pkg::SAVE_BIT], "save bit stored")
	`DSPG_ASSERT_NOW(a_min_floor, clk, arst_n, 1'b1, (regs_q[3] >= dspg_pkg::MIN_FLOOR) && (regs_q[4] >= dspg_pkg::MIN_FLOOR) && (regs_q[5] >= dspg_pkg::MIN_FLOOR) && (regs_q[6] >= dspg_pkg::MIN_FLOOR), "min or max below floor")

endmodule

`default_nettype wire

@@ rtl/dspg_timer.sv @@
// ----------------------------------------------------------------------------
// dspg_timer
// period counter and pulse pin levels, period and base configuration
// ----------------------------------------------------------------------------
`default_nettype none
`include "dual_servo_pulse_generator_defines.svh"

module dspg_timer (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic               cfg_index,
	input  wire logic [11:0]        cfg_data,
	input  wire dspg_pkg::tmr_ctl_t tmr_ctl,
	output logic [1:0]              pins_next
);

	logic [11:0] period_q;
	logic [9:0]  base_q;
	logic [11:0] cnt_q;
	logic [11:0] cnt_next;
	logic [1:0]  pin_q;
	logic [10:0] fall_a;
	logic [10:0] fall_b;
	logic [12:0] cnt_inc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= dspg_pkg::PERIOD_RST;
			base_q   <= dspg_pkg::BASE_RST;
		end else if (cfg_we) begin
			if (cfg_index == dspg_pkg::CFG_PERIOD) begin
				period_q <= cfg_data;
			end else begin
				base_q <= cfg_data[9:0];
			end
		end
	end

	assign fall_a  = {1'b0, base_q} + {3'b000, tmr_ctl.cmp_a};
	assign fall_b  = {1'b0, base_q} + {3'b000, tmr_ctl.cmp_b};
	assign cnt_inc = {1'b0, cnt_q} + 13'd1;

	always_comb begin
		pins_next = pin_q;
		cnt_next  = cnt_q;
		if (tmr_ctl.tick) begin
			if (cnt_q == '0) begin
				pins_next = pins_next | tmr_ctl.en;
			end
			if (cnt_q == {1'b0, fall_a}) begin
				pins_next[0] = 1'b0;
			end
			if (cnt_q == {1'b0, fall_b}) begin
				pins_next[1] = 1'b0;
			end
			cnt_next = (cnt_inc >= {1'b0, period_q}) ? '0 : cnt_inc[11:0];
		end else if (tmr_ctl.wr) begin
			pins_next = pin_q & tmr_ctl.en;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			pin_q <= '0;
		end else begin
			cnt_q <= cnt_next;
			pin_q <= pins_next;
		end
	end

	`DSPG_ASSERT_NEXT(a_disable_drops_a, clk, arst_n, tmr_ctl.wr && !tmr_ctl.en[0], !pin_q[0], "pin a high after disable")
	`DSPG_ASSERT_NEXT(a_disable_drops_b, clk, arst_n, tmr_ctl.wr && !tmr_ctl.en[1], !pin_q[1], "pin b high after disable")

endmodule

`default_nettype wire

@@ rtl/dual_servo_pulse_generator.sv @@
// ----------------------------------------------------------------------------
// dual_servo_pulse_generator
// two-channel servo pulse generator behind a byte register file
// ----------------------------------------------------------------------------
// channel   direction  handshake          payload
// in        input      in_valid/in_stall  req_type, reg_addr, write_data
// out       output     out_valid/out_stall pin_a, pin_b, laser_enable, read_data, save_pulse
// cfg       input      cfg_we             cfg_index, cfg_data
//
// one word per cycle sustained while out_stall is low; a word waits in the input register,
// its result in the result register; these two bound the single logic stage
// reset clears the control state to its defaults at once; no clearing pass;
// the stage and result data registers are not reset; a stalled result holds the stage;
// the input stalls only when both are full and the result is stalled
// ----------------------------------------------------------------------------
`default_nettype none
`include "dual_servo_pulse_generator_defines.svh"

module dual_servo_pulse_generator (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [11:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  req_type,
	input  wire logic [2:0]  reg_addr,
	input  wire logic [7:0]  write_data,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             pin_a,
	output logic             pin_b,
	output logic             laser_enable,
	output logic [7:0]       read_data,
	output logic             save_pulse
);

	logic               valid_s1;
	logic [1:0]         req_s1;
	logic [2:0]         addr_s1;
	logic [7:0]         data_s1;
	logic               out_valid_q;
	logic [1:0]         pins_q;
	logic               laser_q;
	logic [7:0]         rd_q;
	logic               save_q;
	logic               adv;
	logic               accept;
	dspg_pkg::tmr_ctl_t tmr_ctl;
	logic [1:0]         pins_next;
	logic               laser_next;
	logic [7:0]         rd_data;
	logic               save;

	assign adv      = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !adv;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1  <= req_type;
			addr_s1 <= reg_addr;
			data_s1 <= write_data;
		end
		if (adv) begin
			pins_q  <= pins_next;
			laser_q <= laser_next;
			rd_q    <= rd_data;
			save_q  <= save;
		end
	end

	dspg_regfile u_regfile (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (adv),
		.req        (req_s1),
		.addr       (addr_s1),
		.data       (data_s1),
		.tmr_ctl    (tmr_ctl),
		.laser_next (laser_next),
		.rd_data    (rd_data),
		.save       (save)
	);

	dspg_timer u_timer (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.tmr_ctl   (tmr_ctl),
		.pins_next (pins_next)
	);

	assign out_valid    = out_valid_q;
	assign pin_a        = pins_q[0];
	assign pin_b        = pins_q[1];
	assign laser_enable = laser_q;
	assign read_data    = rd_q;
	assign save_pulse   = save_q;

	`DSPG_ASSERT_NOW(a_empty_no_stall, clk, arst_n, !valid_s1, !in_stall,
		"stall with empty stage")
	`DSPG_ASSERT_NOW(a_save_no_read, clk, arst_n, out_valid && save_pulse, read_data == 8'd0,
		"save word carries read data")

endmodule

`default_nettype wire
